>>> hdl/jvs_pkg.sv
// ----------------------------------------------------------------------------
// Joystick velocity smoother package
// Shared constants, register map and control types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package jvs_pkg;

  localparam int AXIS_FIELDS   = 8;
  localparam int BUTTON_FIELDS = 16;
  localparam int NUM_AXES      = 8;
  localparam int NUM_BUTTONS   = 16;
  localparam int AXIS_LIMIT    = (NUM_AXES < AXIS_FIELDS) ? NUM_AXES : AXIS_FIELDS;
  localparam int BUTTON_LIMIT  = (NUM_BUTTONS < BUTTON_FIELDS) ? NUM_BUTTONS : BUTTON_FIELDS;
  localparam int AXIS_IW       = $clog2(AXIS_FIELDS);
  localparam int BTN_IW        = $clog2(BUTTON_FIELDS);
  localparam int NUM_LANES     = 3;

  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  localparam logic [16:0] ONE_Q16 = 17'h10000;

  localparam logic [2:0] REG_SCALE_X       = 3'd0;
  localparam logic [2:0] REG_SCALE_Y       = 3'd1;
  localparam logic [2:0] REG_SCALE_Z       = 3'd2;
  localparam logic [2:0] REG_SMOOTHING     = 3'd3;
  localparam logic [2:0] REG_TIMEOUT       = 3'd4;
  localparam logic [2:0] REG_AXIS_SELECT   = 3'd5;
  localparam logic [2:0] REG_BUTTON_SELECT = 3'd6;

  localparam logic [15:0] RST_SCALE_X       = 16'd1638;
  localparam logic [15:0] RST_SCALE_Y       = 16'd1638;
  localparam logic [15:0] RST_SCALE_Z       = 16'd2458;
  localparam logic [16:0] RST_SMOOTHING     = 17'd13107;
  localparam logic [15:0] RST_TIMEOUT       = 16'd50;
  localparam logic [11:0] RST_AXIS_SELECT   = 12'd513;
  localparam logic [14:0] RST_BUTTON_SELECT = 15'd2085;

  typedef struct packed {
    logic signed [15:0] scale_x;
    logic signed [15:0] scale_y;
    logic signed [15:0] scale_z;
    logic [16:0]        smoothing;
    logic [15:0]        timeout_ticks;
    logic [11:0]        axis_select;
    logic [14:0]        button_select;
  } cfg_t;

  typedef struct packed {
    logic        cmd_en;
    logic        vel_en;
    logic        to_zero;
    logic        clear;
    logic [16:0] weight;
  } lane_ctl_t;

  typedef struct packed {
    logic publish;
    logic grip_request;
    logic release_request;
  } flag_t;

  typedef struct packed {
    logic               publish;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] vel_z;
    logic               grip_request;
    logic               release_request;
  } res_t;

endpackage

>>> hdl/jvs_if.sv
// ----------------------------------------------------------------------------
// Joystick velocity smoother channels
// Valid/ready word channels for joystick items and velocity results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface jvs_in_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [3:0]         axes_present;
  logic [4:0]         buttons_present;
  logic [15:0]        button_bits;
  logic signed [15:0] axis_0;
  logic signed [15:0] axis_1;
  logic signed [15:0] axis_2;
  logic signed [15:0] axis_3;
  logic signed [15:0] axis_4;
  logic signed [15:0] axis_5;
  logic signed [15:0] axis_6;
  logic signed [15:0] axis_7;

  modport source (
    output valid, kind, axes_present, buttons_present, button_bits,
           axis_0, axis_1, axis_2, axis_3, axis_4, axis_5, axis_6, axis_7,
    input  ready
  );
  modport sink (
    input  valid, kind, axes_present, buttons_present, button_bits,
           axis_0, axis_1, axis_2, axis_3, axis_4, axis_5, axis_6, axis_7,
    output ready
  );
endinterface

interface jvs_out_if;
  logic               valid;
  logic               ready;
  logic               publish;
  logic signed [15:0] vel_x;
  logic signed [15:0] vel_y;
  logic signed [15:0] vel_z;
  logic               grip_request;
  logic               release_request;

  modport source (
    output valid, publish, vel_x, vel_y, vel_z, grip_request, release_request,
    input  ready
  );
  modport sink (
    input  valid, publish, vel_x, vel_y, vel_z, grip_request, release_request,
    output ready
  );
endinterface

>>> hdl/jvs_cfg.sv
// ----------------------------------------------------------------------------
// Joystick velocity smoother register file
// APB-style register bank for gains, smoothing, timeout and selections.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jvs_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [jvs_pkg::PADDR_W-1:0]  paddr,
  input  logic [jvs_pkg::PDATA_W-1:0]  pwdata,
  output logic [jvs_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output jvs_pkg::cfg_t                cfg
);

  jvs_pkg::cfg_t cfg_r;
  jvs_pkg::cfg_t cfg_nxt;
  logic [2:0]    idx;
  logic          wr;

  assign idx    = paddr[jvs_pkg::PADDR_W-1:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      case (idx)
        jvs_pkg::REG_SCALE_X:       cfg_nxt.scale_x       = pwdata[15:0];
        jvs_pkg::REG_SCALE_Y:       cfg_nxt.scale_y       = pwdata[15:0];
        jvs_pkg::REG_SCALE_Z:       cfg_nxt.scale_z       = pwdata[15:0];
        jvs_pkg::REG_SMOOTHING:     cfg_nxt.smoothing     = pwdata[16:0];
        jvs_pkg::REG_TIMEOUT:       cfg_nxt.timeout_ticks = pwdata[15:0];
        jvs_pkg::REG_AXIS_SELECT:   cfg_nxt.axis_select   = pwdata[11:0];
        jvs_pkg::REG_BUTTON_SELECT: cfg_nxt.button_select = pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      jvs_pkg::REG_SCALE_X:       prdata = {16'd0, cfg_r.scale_x};
      jvs_pkg::REG_SCALE_Y:       prdata = {16'd0, cfg_r.scale_y};
      jvs_pkg::REG_SCALE_Z:       prdata = {16'd0, cfg_r.scale_z};
      jvs_pkg::REG_SMOOTHING:     prdata = {15'd0, cfg_r.smoothing};
      jvs_pkg::REG_TIMEOUT:       prdata = {16'd0, cfg_r.timeout_ticks};
      jvs_pkg::REG_AXIS_SELECT:   prdata = {20'd0, cfg_r.axis_select};
      jvs_pkg::REG_BUTTON_SELECT: prdata = {17'd0, cfg_r.button_select};
      default:                    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.scale_x       <= jvs_pkg::RST_SCALE_X;
      cfg_r.scale_y       <= jvs_pkg::RST_SCALE_Y;
      cfg_r.scale_z       <= jvs_pkg::RST_SCALE_Z;
      cfg_r.smoothing     <= jvs_pkg::RST_SMOOTHING;
      cfg_r.timeout_ticks <= jvs_pkg::RST_TIMEOUT;
      cfg_r.axis_select   <= jvs_pkg::RST_AXIS_SELECT;
      cfg_r.button_select <= jvs_pkg::RST_BUTTON_SELECT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

>>> hdl/jvs_ctrl.sv
// ----------------------------------------------------------------------------
// Joystick velocity smoother control
// Deadman latch, activity and tick counting, button decode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jvs_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic               kind,
  input  logic [4:0]         buttons_present,
  input  logic [15:0]        button_bits,
  input  jvs_pkg::cfg_t      cfg,
  output jvs_pkg::lane_ctl_t lane_ctl,
  output jvs_pkg::flag_t     flags
);

  logic        deadman_r, deadman_nxt;
  logic        active_r, active_nxt;
  logic [15:0] ticks_r, ticks_nxt;
  logic [4:0]  btn_n;
  logic        dm_on, grip_on, rel_on;
  logic        rep_acc, tick_acc;
  logic [16:0] elapsed;
  logic        timed_out;

  function automatic logic btn_on(input logic [4:0] idx, input logic [4:0] n,
                                  input logic [15:0] bits);
    logic hit;
    hit = (idx < n) ? bits[idx[jvs_pkg::BTN_IW-1:0]] : 1'b0;
    return hit;
  endfunction

  assign btn_n = (buttons_present > 5'(jvs_pkg::BUTTON_LIMIT)) ?
                 5'(jvs_pkg::BUTTON_LIMIT) : buttons_present;
  assign dm_on   = btn_on(cfg.button_select[4:0],   btn_n, button_bits);
  assign grip_on = btn_on(cfg.button_select[9:5],   btn_n, button_bits);
  assign rel_on  = btn_on(cfg.button_select[14:10], btn_n, button_bits);

  assign rep_acc   = accept && !kind;
  assign tick_acc  = accept && kind;
  assign elapsed   = {1'b0, ticks_r} + 17'd1;
  assign timed_out = elapsed > {1'b0, cfg.timeout_ticks};

  assign lane_ctl.cmd_en  = rep_acc;
  assign lane_ctl.vel_en  = tick_acc && (deadman_r || active_r);
  assign lane_ctl.to_zero = !deadman_r;
  assign lane_ctl.clear   = !deadman_r && active_r && timed_out;
  assign lane_ctl.weight  = (cfg.smoothing > jvs_pkg::ONE_Q16) ?
                            jvs_pkg::ONE_Q16 : cfg.smoothing;

  assign flags.publish         = kind && (deadman_r || active_r);
  assign flags.grip_request    = !kind && grip_on;
  assign flags.release_request = !kind && !grip_on && rel_on;

  always_comb begin
    deadman_nxt = deadman_r;
    active_nxt  = active_r;
    ticks_nxt   = ticks_r;
    if (rep_acc) begin
      deadman_nxt = dm_on;
      if (dm_on) begin
        active_nxt = 1'b1;
        ticks_nxt  = '0;
      end
    end else if (tick_acc) begin
      if (!deadman_r && active_r && timed_out) begin
        active_nxt = 1'b0;
      end
      ticks_nxt = elapsed[16] ? 16'hFFFF : elapsed[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadman_r <= 1'b0;
      active_r  <= 1'b0;
      ticks_r   <= '0;
    end else begin
      deadman_r <= deadman_nxt;
      active_r  <= active_nxt;
      ticks_r   <= ticks_nxt;
    end
  end

endmodule

>>> hdl/jvs_lane.sv
// ----------------------------------------------------------------------------
// Joystick velocity smoother lane
// One velocity axis: axis pick and gain to a command, exponential average.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jvs_lane (
  input  logic                      clk,
  input  logic                      rst_n,
  input  jvs_pkg::lane_ctl_t        ctl,
  input  logic [3:0]                axis_idx,
  input  logic [3:0]                axes_n,
  input  logic signed [15:0]        axes [jvs_pkg::AXIS_FIELDS],
  input  logic signed [15:0]        gain,
  output logic signed [15:0]        vel_nxt
);

  logic signed [15:0] command_r, command_nxt;
  logic signed [15:0] velocity_r;
  logic signed [15:0] axis_val;
  logic signed [31:0] cmd_prod;
  logic signed [16:0] cmd_sh, cmd_q;
  logic               cmd_rnd;
  logic signed [15:0] target;
  logic signed [16:0] diff;
  logic signed [17:0] wgt;
  logic signed [34:0] mix_prod, base, sum;
  logic signed [18:0] bl_sh, bl_q;
  logic               bl_rnd;
  logic signed [15:0] blended;

  function automatic logic signed [15:0] sat16(input logic signed [18:0] x);
    logic signed [15:0] r;
    if (x > 19'sd32767) begin
      r = 16'sh7FFF;
    end else if (x < -19'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = x[15:0];
    end
    return r;
  endfunction

  assign axis_val = axes[axis_idx[jvs_pkg::AXIS_IW-1:0]];
  assign cmd_prod = gain * axis_val;
  assign cmd_sh   = cmd_prod[31:15];
  assign cmd_rnd  = cmd_prod[31] && (|cmd_prod[14:0]);
  assign cmd_q    = cmd_sh + {16'd0, cmd_rnd};

  always_comb begin
    command_nxt = command_r;
    if (ctl.cmd_en && (axis_idx < axes_n)) begin
      command_nxt = sat16(19'(cmd_q));
    end
  end

  assign target   = ctl.to_zero ? 16'sd0 : command_r;
  assign diff     = 17'(target) - 17'(velocity_r);
  assign wgt      = $signed({1'b0, ctl.weight});
  assign mix_prod = diff * wgt;
  assign base     = {{3{velocity_r[15]}}, velocity_r, 16'd0};
  assign sum      = base + mix_prod;
  assign bl_sh    = sum[34:16];
  assign bl_rnd   = sum[34] && (|sum[15:0]);
  assign bl_q     = bl_sh + {18'd0, bl_rnd};
  assign blended  = sat16(bl_q);

  always_comb begin
    vel_nxt = velocity_r;
    if (ctl.vel_en) begin
      vel_nxt = ctl.clear ? 16'sd0 : blended;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      command_r  <= '0;
      velocity_r <= '0;
    end else begin
      command_r  <= command_nxt;
      velocity_r <= vel_nxt;
    end
  end

endmodule

>>> hdl/jvs_merge.sv
// ----------------------------------------------------------------------------
// Joystick velocity smoother merge
// Combine lane velocities and flags into a result word, two-entry buffer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jvs_merge (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  jvs_pkg::flag_t     flags,
  input  logic signed [15:0] vel [jvs_pkg::NUM_LANES],
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output jvs_pkg::res_t      out_word
);

  jvs_pkg::res_t word;
  jvs_pkg::res_t main_r, main_nxt;
  jvs_pkg::res_t skid_r, skid_nxt;
  logic          main_v_r, main_v_nxt;
  logic          skid_v_r, skid_v_nxt;
  logic          pop;

  assign word.publish         = flags.publish;
  assign word.vel_x           = flags.publish ? vel[0] : 16'sd0;
  assign word.vel_y           = flags.publish ? vel[1] : 16'sd0;
  assign word.vel_z           = flags.publish ? vel[2] : 16'sd0;
  assign word.grip_request    = flags.grip_request;
  assign word.release_request = flags.release_request;

  assign pop       = main_v_r && out_ready;
  assign in_ready  = !skid_v_r;
  assign out_valid = main_v_r;
  assign out_word  = main_r;

  always_comb begin
    main_nxt   = main_r;
    main_v_nxt = main_v_r;
    skid_nxt   = skid_r;
    skid_v_nxt = skid_v_r;
    if (skid_v_r) begin
      if (pop) begin
        main_nxt   = skid_r;
        skid_v_nxt = 1'b0;
      end
    end else if (pop || !main_v_r) begin
      main_nxt   = word;
      main_v_nxt = push;
    end else if (push) begin
      skid_nxt   = word;
      skid_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

`ifndef NO_ASSERTIONS
  a_skid_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> main_v_r)
    else $error("skid entry held without main entry");

  a_quiet_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (main_v_r && !main_r.publish) |->
      (main_r.vel_x == 16'sd0 && main_r.vel_y == 16'sd0 && main_r.vel_z == 16'sd0))
    else $error("non-published word carries velocity");

  a_grip_wins: assert property (@(posedge clk) disable iff (!rst_n)
    main_v_r |-> !(main_r.grip_request && main_r.release_request))
    else $error("grip and release raised together");

  a_tick_no_req: assert property (@(posedge clk) disable iff (!rst_n)
    (main_v_r && main_r.publish) |->
      (!main_r.grip_request && !main_r.release_request))
    else $error("published word carries gripper request");
`endif

endmodule

>>> hdl/joystick_velocity_smoother.sv
// ----------------------------------------------------------------------------
// Joystick velocity smoother
// Accepted words are registered in the result buffer; three velocity lanes
// update at acceptance. Throughput: one word per cycle unless skid is full.
// A two-entry result buffer keeps the input open while one word waits.
// Synchronous active-low reset clears state and restores register defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module joystick_velocity_smoother (
  input  logic                         clk,
  input  logic                         rst_n,
  jvs_in_if.sink                       in_chan,
  jvs_out_if.source                    out_chan,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [jvs_pkg::PADDR_W-1:0]  paddr,
  input  logic [jvs_pkg::PDATA_W-1:0]  pwdata,
  output logic [jvs_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);

  jvs_pkg::cfg_t      cfg;
  jvs_pkg::lane_ctl_t lane_ctl;
  jvs_pkg::flag_t     flags;
  jvs_pkg::res_t      out_word;
  logic               accept;
  logic               in_ready;
  logic [3:0]         axes_n;
  logic signed [15:0] axes  [jvs_pkg::AXIS_FIELDS];
  logic signed [15:0] gains [jvs_pkg::NUM_LANES];
  logic signed [15:0] vel   [jvs_pkg::NUM_LANES];

  assign in_chan.ready = in_ready;
  assign accept        = in_chan.valid && in_ready;

  assign axes[0] = in_chan.axis_0;
  assign axes[1] = in_chan.axis_1;
  assign axes[2] = in_chan.axis_2;
  assign axes[3] = in_chan.axis_3;
  assign axes[4] = in_chan.axis_4;
  assign axes[5] = in_chan.axis_5;
  assign axes[6] = in_chan.axis_6;
  assign axes[7] = in_chan.axis_7;

  assign axes_n = (in_chan.axes_present > 4'(jvs_pkg::AXIS_LIMIT)) ?
                  4'(jvs_pkg::AXIS_LIMIT) : in_chan.axes_present;

  assign gains[0] = cfg.scale_x;
  assign gains[1] = cfg.scale_y;
  assign gains[2] = cfg.scale_z;

  jvs_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  jvs_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (accept),
    .kind            (in_chan.kind),
    .buttons_present (in_chan.buttons_present),
    .button_bits     (in_chan.button_bits),
    .cfg             (cfg),
    .lane_ctl        (lane_ctl),
    .flags           (flags)
  );

  for (genvar i = 0; i < jvs_pkg::NUM_LANES; i++) begin : g_lane
    jvs_lane u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (lane_ctl),
      .axis_idx (cfg.axis_select[4*i +: 4]),
      .axes_n   (axes_n),
      .axes     (axes),
      .gain     (gains[i]),
      .vel_nxt  (vel[i])
    );
  end

  jvs_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .flags     (flags),
    .vel       (vel),
    .in_ready  (in_ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_word  (out_word)
  );

  assign out_chan.publish         = out_word.publish;
  assign out_chan.vel_x           = out_word.vel_x;
  assign out_chan.vel_y           = out_word.vel_y;
  assign out_chan.vel_z           = out_word.vel_z;
  assign out_chan.grip_request    = out_word.grip_request;
  assign out_chan.release_request = out_word.release_request;

endmodule

>>> verif/jvs_tb_pkg.sv
// ----------------------------------------------------------------------------
// Joystick velocity smoother test package
// Word kinds and the stimulus word shared by the test top and the checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package jvs_tb_pkg;

  typedef enum logic {
    WORD_REPORT = 1'b0,
    WORD_TICK   = 1'b1
  } word_kind_e;

  typedef struct {
    word_kind_e         kind;
    logic [3:0]         axes_present;
    logic [4:0]         buttons_present;
    logic [15:0]        button_bits;
    logic signed [15:0] axis [8];
  } joy_word_t;

endpackage

>>> verif/jvs_checker.sv
// ----------------------------------------------------------------------------
// Joystick velocity smoother checker
// Watches both word channels and the register port, keeps its own copy of the
// smoother state, predicts every result word and compares it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jvs_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  jvs_in_if                           in_mon,
  jvs_out_if                          out_mon,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [jvs_pkg::PADDR_W-1:0] paddr,
  input  logic [jvs_pkg::PDATA_W-1:0] pwdata,
  input  logic                        pready,
  output int                          mismatches,
  output int                          backlog,
  output int                          reports_seen,
  output int                          ticks_seen,
  output int                          publishes_seen
);
  import jvs_pkg::*;
  import jvs_tb_pkg::*;

  cfg_t               regs;
  logic signed [15:0] command [NUM_LANES];
  logic signed [15:0] velocity [NUM_LANES];
  logic               deadman;
  logic               active;
  logic [15:0]        since_press;
  res_t               velocity_words [$];

  initial begin
    mismatches     = 0;
    backlog        = 0;
    reports_seen   = 0;
    ticks_seen     = 0;
    publishes_seen = 0;
  end

  function automatic logic signed [15:0] sat16(longint x);
    if (x > 32767) return 16'h7FFF;
    if (x < -32768) return 16'h8000;
    return x[15:0];
  endfunction

  function automatic longint shift_toward_zero(longint x, int n);
    return (x < 0) ? -((-x) >>> n) : (x >>> n);
  endfunction

  function automatic logic signed [15:0] blend(longint target, longint now, longint w);
    return sat16(shift_toward_zero(target * w + now * (longint'(ONE_Q16) - w), 16));
  endfunction

  function automatic logic signed [15:0] scaled(logic signed [15:0] gain,
                                                logic signed [15:0] pos);
    return sat16(shift_toward_zero(longint'(gain) * longint'(pos), 15));
  endfunction

  function automatic logic button_on(logic [15:0] bits, logic [4:0] present,
                                     logic [4:0] idx);
    int n;
    n = (present > BUTTON_LIMIT) ? BUTTON_LIMIT : present;
    return (idx < n) ? bits[idx[3:0]] : 1'b0;
  endfunction

  task automatic clear_state();
    regs = '{scale_x: RST_SCALE_X, scale_y: RST_SCALE_Y, scale_z: RST_SCALE_Z,
             smoothing: RST_SMOOTHING, timeout_ticks: RST_TIMEOUT,
             axis_select: RST_AXIS_SELECT, button_select: RST_BUTTON_SELECT};
    for (int lane = 0; lane < NUM_LANES; lane++) begin
      command[lane]  = '0;
      velocity[lane] = '0;
    end
    deadman     = 1'b0;
    active      = 1'b0;
    since_press = '0;
    velocity_words.delete();
  endtask

  function automatic res_t smooth_step();
    res_t               r;
    logic signed [15:0] pos [AXIS_FIELDS];
    logic signed [15:0] gain [NUM_LANES];
    logic [4:0]         bp;
    logic [15:0]        bits;
    logic [3:0]         sel;
    int                 n_axes;
    longint             w;
    logic [16:0]        elapsed;
    r    = '0;
    pos  = '{in_mon.axis_0, in_mon.axis_1, in_mon.axis_2, in_mon.axis_3,
             in_mon.axis_4, in_mon.axis_5, in_mon.axis_6, in_mon.axis_7};
    gain = '{regs.scale_x, regs.scale_y, regs.scale_z};
    bp   = in_mon.buttons_present;
    bits = in_mon.button_bits;
    if (in_mon.kind == WORD_REPORT) begin
      deadman = button_on(bits, bp, regs.button_select[4:0]);
      if (deadman) begin
        active      = 1'b1;
        since_press = '0;
      end
      n_axes = (in_mon.axes_present > AXIS_LIMIT) ? AXIS_LIMIT : in_mon.axes_present;
      for (int lane = 0; lane < NUM_LANES; lane++) begin
        sel = regs.axis_select[4*lane +: 4];
        if (sel < n_axes) command[lane] = scaled(gain[lane], pos[sel]);
      end
      if (button_on(bits, bp, regs.button_select[9:5])) r.grip_request = 1'b1;
      else if (button_on(bits, bp, regs.button_select[14:10])) r.release_request = 1'b1;
    end else begin
      w       = (regs.smoothing > ONE_Q16) ? ONE_Q16 : regs.smoothing;
      elapsed = {1'b0, since_press} + 17'd1;
      if (deadman) begin
        for (int lane = 0; lane < NUM_LANES; lane++)
          velocity[lane] = blend(command[lane], velocity[lane], w);
        r.publish = 1'b1;
      end else if (active) begin
        if (elapsed > {1'b0, regs.timeout_ticks}) begin
          for (int lane = 0; lane < NUM_LANES; lane++) velocity[lane] = '0;
          active = 1'b0;
        end else begin
          for (int lane = 0; lane < NUM_LANES; lane++)
            velocity[lane] = blend(0, velocity[lane], w);
        end
        r.publish = 1'b1;
      end
      since_press = elapsed[16] ? 16'hFFFF : elapsed[15:0];
      if (r.publish) begin
        r.vel_x = velocity[0];
        r.vel_y = velocity[1];
        r.vel_z = velocity[2];
      end
    end
    return r;
  endfunction

  task automatic check_field(string name, logic signed [31:0] want, logic signed [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    res_t want;
    if (!rst_n) begin
      clear_state();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (velocity_words.size() == 0) begin
          mismatches++;
          $display("%0t: result word with nothing outstanding", $time);
        end else begin
          want = velocity_words.pop_front();
          check_field("publish", want.publish, out_mon.publish);
          check_field("vel_x", want.vel_x, out_mon.vel_x);
          check_field("vel_y", want.vel_y, out_mon.vel_y);
          check_field("vel_z", want.vel_z, out_mon.vel_z);
          check_field("grip_request", want.grip_request, out_mon.grip_request);
          check_field("release_request", want.release_request, out_mon.release_request);
        end
        if (out_mon.publish === 1'b1) publishes_seen++;
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.kind == WORD_REPORT) reports_seen++;
        else ticks_seen++;
        velocity_words.push_back(smooth_step());
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[PADDR_W-1:2])
          REG_SCALE_X:       regs.scale_x       = pwdata[15:0];
          REG_SCALE_Y:       regs.scale_y       = pwdata[15:0];
          REG_SCALE_Z:       regs.scale_z       = pwdata[15:0];
          REG_SMOOTHING:     regs.smoothing     = pwdata[16:0];
          REG_TIMEOUT:       regs.timeout_ticks = pwdata[15:0];
          REG_AXIS_SELECT:   regs.axis_select   = pwdata[11:0];
          REG_BUTTON_SELECT: regs.button_select = pwdata[14:0];
          default: ;
        endcase
      end
    end
    backlog = velocity_words.size();
  end

endmodule

>>> verif/joystick_velocity_smoother_test.sv
// ----------------------------------------------------------------------------
// Joystick velocity smoother test
// Directed joystick reports and control ticks, then deadman sessions with
// random content under several register settings, and one long release
// that runs the tick count past the timeout. Both channels idle in
// random bursts; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module joystick_velocity_smoother_test;
  import jvs_pkg::*;
  import jvs_tb_pkg::*;

  logic               clk;
  logic               rst_n;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  int                 mismatches;
  int                 backlog;
  int                 reports_seen;
  int                 ticks_seen;
  int                 publishes_seen;
  int                 words_sent;
  int                 reg_writes;
  bit                 calm;
  logic [14:0]        btn_sel_now;

  jvs_in_if  in_chan ();
  jvs_out_if out_chan ();

  joystick_velocity_smoother u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  jvs_checker u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_chan),
    .out_mon        (out_chan),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .pready         (pready),
    .mismatches     (mismatches),
    .backlog        (backlog),
    .reports_seen   (reports_seen),
    .ticks_seen     (ticks_seen),
    .publishes_seen (publishes_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  // stall the result side in short bursts
  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 7) == 0) begin
        out_chan.ready = 1'b0;
        repeat ($urandom_range(1, 9) - 1) @(negedge clk);
      end else begin
        out_chan.ready = 1'b1;
      end
    end
  end

  function automatic logic signed [15:0] pick_axis();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return '0;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [4:0] pick_index(int span);
    return ($urandom_range(0, 5) == 0) ? 5'($urandom) : 5'($urandom_range(0, span - 1));
  endfunction

  function automatic joy_word_t random_word(word_kind_e kind);
    joy_word_t w;
    w.kind            = kind;
    w.axes_present    = ($urandom_range(0, 5) == 0) ? 4'($urandom)
                                                    : 4'($urandom_range(0, AXIS_FIELDS));
    w.buttons_present = ($urandom_range(0, 5) == 0) ? 5'($urandom)
                                                    : 5'($urandom_range(0, BUTTON_FIELDS));
    w.button_bits     = 16'($urandom);
    foreach (w.axis[i]) w.axis[i] = pick_axis();
    return w;
  endfunction

  function automatic joy_word_t report_of(logic [3:0] ap, logic [4:0] bp, logic [15:0] bits);
    joy_word_t w;
    w                 = random_word(WORD_REPORT);
    w.axes_present    = ap;
    w.buttons_present = bp;
    w.button_bits     = bits;
    return w;
  endfunction

  function automatic joy_word_t flat(joy_word_t w, logic signed [15:0] v);
    foreach (w.axis[i]) w.axis[i] = v;
    return w;
  endfunction

  function automatic joy_word_t session_report(logic hold);
    joy_word_t  w;
    logic [4:0] dm;
    w  = random_word(WORD_REPORT);
    dm = btn_sel_now[4:0];
    if ($urandom_range(0, 3) != 0) begin
      w.axes_present    = AXIS_FIELDS;
      w.buttons_present = BUTTON_FIELDS;
    end
    if (dm < BUTTON_FIELDS) w.button_bits[dm[3:0]] = hold;
    return w;
  endfunction

  task automatic send_word(joy_word_t w);
    int gap;
    gap = (!calm && $urandom_range(0, 5) == 0) ? $urandom_range(1, 9) : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_chan.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chan.kind            = w.kind;
    in_chan.axes_present    = w.axes_present;
    in_chan.buttons_present = w.buttons_present;
    in_chan.button_bits     = w.button_bits;
    in_chan.axis_0          = w.axis[0];
    in_chan.axis_1          = w.axis[1];
    in_chan.axis_2          = w.axis[2];
    in_chan.axis_3          = w.axis[3];
    in_chan.axis_4          = w.axis[4];
    in_chan.axis_5          = w.axis[5];
    in_chan.axis_6          = w.axis[6];
    in_chan.axis_7          = w.axis[7];
    in_chan.valid           = 1'b1;
    do @(posedge clk); while (!in_chan.ready);
    words_sent++;
  endtask

  task automatic settle();
    @(negedge clk);
    in_chan.valid = 1'b0;
    while (backlog != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    if (idx == REG_BUTTON_SELECT) btn_sel_now = value[14:0];
    reg_writes++;
  endtask

  task automatic random_setup();
    logic [16:0] smooth;
    logic [4:0]  ax_x;
    logic [4:0]  ax_y;
    logic [4:0]  ax_z;
    case ($urandom_range(0, 4))
      0:       smooth = '0;
      1:       smooth = ONE_Q16;
      2:       smooth = 17'h1FFFF;
      3:       smooth = 17'($urandom);
      default: smooth = 17'($urandom_range(1, 65535));
    endcase
    ax_x = pick_index(AXIS_FIELDS);
    ax_y = pick_index(AXIS_FIELDS);
    ax_z = pick_index(AXIS_FIELDS);
    write_reg(REG_SCALE_X, 32'($urandom & 16'hFFFF));
    write_reg(REG_SCALE_Y, 32'($urandom & 16'hFFFF));
    write_reg(REG_SCALE_Z, 32'($urandom & 16'hFFFF));
    write_reg(REG_SMOOTHING, 32'(smooth));
    write_reg(REG_TIMEOUT, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                       : $urandom_range(0, 12));
    write_reg(REG_AXIS_SELECT, {20'd0, ax_z[3:0], ax_y[3:0], ax_x[3:0]});
    write_reg(REG_BUTTON_SELECT, {17'd0, pick_index(BUTTON_FIELDS),
                                  pick_index(BUTTON_FIELDS), pick_index(BUTTON_FIELDS)});
  endtask

  task automatic run_session();
    send_word(session_report(1'b1));
    repeat ($urandom_range(1, 10)) begin
      if ($urandom_range(0, 3) == 0) send_word(session_report(1'b1));
      else send_word(random_word(WORD_TICK));
    end
    send_word(session_report(1'b0));
    repeat ($urandom_range(0, 14)) send_word(random_word(WORD_TICK));
  endtask

  task automatic random_phase(int count);
    int target;
    target = words_sent + count;
    while (words_sent < target) begin
      if ($urandom_range(0, 4) == 0)
        send_word(random_word(word_kind_e'($urandom_range(0, 1))));
      else
        run_session();
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    calm        = 1'b0;
    words_sent  = 0;
    reg_writes  = 0;
    btn_sel_now = RST_BUTTON_SELECT;
    in_chan.valid           = 1'b0;
    in_chan.kind            = WORD_REPORT;
    in_chan.axes_present    = '0;
    in_chan.buttons_present = '0;
    in_chan.button_bits     = '0;
    in_chan.axis_0          = '0;
    in_chan.axis_1          = '0;
    in_chan.axis_2          = '0;
    in_chan.axis_3          = '0;
    in_chan.axis_4          = '0;
    in_chan.axis_5          = '0;
    in_chan.axis_6          = '0;
    in_chan.axis_7          = '0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // reset settings: deadman 5, grip 1, release 2; x axis 1, y axis 0, z axis 2
    send_word(random_word(WORD_TICK));
    send_word(report_of(4'd8, 5'd16, 16'h0004));
    send_word(report_of(4'd8, 5'd16, 16'h0006));
    send_word(flat(report_of(4'd8, 5'd16, 16'h0020), 16'h7FFF));
    send_word(random_word(WORD_TICK));
    send_word(random_word(WORD_TICK));
    send_word(flat(report_of(4'd8, 5'd16, 16'h0020), 16'h8000));
    send_word(random_word(WORD_TICK));
    send_word(report_of(4'd1, 5'd16, 16'h0020));
    send_word(report_of(4'd8, 5'd5, 16'h0020));
    send_word(random_word(WORD_TICK));
    send_word(report_of(4'd15, 5'd31, 16'hFFFF));

    settle();
    write_reg(REG_SCALE_X, 32'h0000_7FFF);
    write_reg(REG_SCALE_Y, 32'h0000_8000);
    write_reg(REG_SCALE_Z, 32'h0000_FFFF);
    write_reg(REG_SMOOTHING, 32'h0001_FFFF);
    write_reg(REG_TIMEOUT, 32'd0);
    write_reg(REG_AXIS_SELECT, {20'd0, 4'hF, 4'd7, 4'd0});
    write_reg(REG_BUTTON_SELECT, {17'd0, 5'd31, 5'd15, 5'd0});
    send_word(flat(report_of(4'd8, 5'd16, 16'h0001), 16'h8000));
    send_word(random_word(WORD_TICK));
    send_word(report_of(4'd8, 5'd16, 16'h8000));
    send_word(random_word(WORD_TICK));
    send_word(random_word(WORD_TICK));

    settle();
    write_reg(REG_SMOOTHING, 32'd0);
    write_reg(REG_TIMEOUT, 32'd2);
    send_word(report_of(4'd8, 5'd16, 16'h0001));
    send_word(random_word(WORD_TICK));
    send_word(report_of(4'd8, 5'd16, 16'h0000));
    repeat (4) send_word(random_word(WORD_TICK));

    repeat (4) begin
      settle();
      random_setup();
      random_phase(100);
    end
    settle();
    calm = 1'b1;
    random_setup();
    random_phase(100);

    // hold released past the timeout so the velocities clear
    settle();
    write_reg(REG_TIMEOUT, 32'd30);
    write_reg(REG_SMOOTHING, 32'(ONE_Q16));
    send_word(session_report(1'b1));
    send_word(session_report(1'b0));
    repeat (36) send_word(random_word(WORD_TICK));

    @(negedge clk);
    in_chan.valid = 1'b0;
    for (int i = 0; i < 2000 && backlog != 0; i++) @(negedge clk);
    repeat (4) @(negedge clk);
    if (backlog != 0) $display("%0d result words never arrived", backlog);
    $display("covered %0d reports and %0d ticks, %0d velocity words published, %0d register writes",
             reports_seen, ticks_seen, publishes_seen, reg_writes);
    if (mismatches == 0 && backlog == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> joystick_velocity_smoother.f
hdl/jvs_pkg.sv
hdl/jvs_if.sv
hdl/jvs_cfg.sv
hdl/jvs_ctrl.sv
hdl/jvs_lane.sv
hdl/jvs_merge.sv
hdl/joystick_velocity_smoother.sv
verif/jvs_tb_pkg.sv
verif/jvs_checker.sv
verif/joystick_velocity_smoother_test.sv
